@@ design/smt_pkg.sv @@
package smt_pkg;

    localparam int CAPACITY     = 16;
    localparam int ELEMENT_BITS = 32;

    localparam int KIND_W   = 2;
    localparam int ELEM_IN_W = 32;
    localparam int COUNT_W  = 5;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ELEM_IN_W-1:0] element;
    } t_in;

    typedef struct packed {
        logic               was_present;
        logic [COUNT_W-1:0] member_count;
        logic               is_empty;
        logic               insert_dropped;
    } t_out;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

@@ design/smt_ctrl.sv @@
module smt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  smt_pkg::t_stat i_stat,
    output smt_pkg::t_cmd  o_cmd
);

    smt_pkg::t_state r_state;
    smt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = smt_pkg::ST_SCAN;
                end
            end
            smt_pkg::ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = smt_pkg::ST_UPDATE;
                end
            end
            smt_pkg::ST_UPDATE: begin
                if (i_stat.out_free) begin
                    n_state = smt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.start     = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.update    = 1'b0;
        unique case (r_state)
            smt_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            smt_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            smt_pkg::ST_UPDATE: begin
                o_cmd.update = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // The scan always ends in the update state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smt_pkg::ST_SCAN) && i_stat.scan_last |=> (r_state == smt_pkg::ST_UPDATE))
        else $error("scan did not hand over to update");

    // A result is written only when the output register can take it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> i_stat.out_free)
        else $error("update issued while output register is occupied");

    // An accepted item always starts a scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == smt_pkg::ST_SCAN))
        else $error("accepted item did not start a scan");

endmodule

@@ design/smt_datapath.sv @@
module smt_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smt_pkg::t_in   i_in_data,
    input  smt_pkg::t_cmd  i_cmd,
    output smt_pkg::t_stat o_stat,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output smt_pkg::t_out  o_out_data
);

    logic [smt_pkg::KIND_W-1:0]       r_kind;
    logic [smt_pkg::ELEMENT_BITS-1:0] r_elem;
    logic [smt_pkg::IDX_W-1:0]        r_idx;
    logic                             r_hit;
    logic [smt_pkg::IDX_W-1:0]        r_hit_idx;
    logic                             r_free_found;
    logic [smt_pkg::IDX_W-1:0]        r_free_idx;

    logic [smt_pkg::ELEMENT_BITS-1:0] r_slot_value [smt_pkg::CAPACITY];
    logic [smt_pkg::CAPACITY-1:0]     r_slot_valid;
    logic [smt_pkg::CNT_W-1:0]        r_live_count;
    logic [smt_pkg::CNT_W-1:0]        n_live_count;

    smt_pkg::t_out r_out;
    logic          r_out_valid;

    logic w_slot_match;
    logic w_is_insert;
    logic w_is_remove;
    logic w_new_insert;
    logic w_do_insert;
    logic w_do_remove;
    logic w_dropped;

    assign w_slot_match = r_slot_valid[r_idx] && (r_slot_value[r_idx] == r_elem);

    assign o_stat.scan_last = (r_idx == smt_pkg::IDX_W'(smt_pkg::CAPACITY - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Kind codes other than insert and remove behave as a lookup.
    always_comb begin
        w_is_insert = 1'b0;
        w_is_remove = 1'b0;
        unique case (r_kind)
            smt_pkg::KIND_INSERT: w_is_insert = 1'b1;
            smt_pkg::KIND_REMOVE: w_is_remove = 1'b1;
            default: begin
                w_is_insert = 1'b0;
                w_is_remove = 1'b0;
            end
        endcase
    end

    assign w_new_insert = i_cmd.update && w_is_insert && !r_hit;
    assign w_do_insert  = w_new_insert && r_free_found;
    assign w_dropped    = w_new_insert && !r_free_found;
    assign w_do_remove  = i_cmd.update && w_is_remove && r_hit;

    always_comb begin
        n_live_count = r_live_count;
        if (w_do_insert) begin
            n_live_count = r_live_count + smt_pkg::CNT_W'(1);
        end else if (w_do_remove && (r_live_count != '0)) begin
            n_live_count = r_live_count - smt_pkg::CNT_W'(1);
        end
    end

    // Item registers and the slot scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step && !o_stat.scan_last) begin
            r_idx <= r_idx + smt_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind       <= i_in_data.kind;
            r_elem       <= i_in_data.element[smt_pkg::ELEMENT_BITS-1:0];
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (w_slot_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (!r_slot_valid[r_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
        end
    end

    // Slot store: values carry no reset, the valid bits do.
    always_ff @(posedge i_clk) begin
        if (w_do_insert) begin
            r_slot_value[r_free_idx] <= r_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_live_count <= '0;
        end else begin
            if (w_do_insert) begin
                r_slot_valid[r_free_idx] <= 1'b1;
            end
            if (w_do_remove) begin
                r_slot_valid[r_hit_idx] <= 1'b0;
            end
            r_live_count <= n_live_count;
        end
    end

    // Output register holds a finished result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out.was_present    <= r_hit;
            r_out.member_count   <= smt_pkg::COUNT_W'(n_live_count);
            r_out.is_empty       <= (n_live_count == '0);
            r_out.insert_dropped <= w_dropped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == 32'(r_live_count))
        else $error("live count disagrees with valid bits");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.insert_dropped
            |-> (r_out.member_count == smt_pkg::COUNT_W'(smt_pkg::CAPACITY)))
        else $error("insert dropped while store was not full");

    // A result that waits for its transfer stays valid and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("waiting result changed before its transfer");

endmodule

@@ design/set_membership_table_core.sv @@
// Channel  | Signals                              | Payload
// ---------+--------------------------------------+------------------------------
// in       | i_in_valid, o_in_ready, i_in_data    | kind, element
// out      | o_out_valid, i_out_ready, o_out_data | was_present, member_count,
//          |                                      | is_empty, insert_dropped
//
// Each item passes through a transfer in the idle state, a compare per slot
// that walks the store, and an update.
// Reset is synchronous on i_rst_n and clears the valid bits and the count.
// A finished result waits in the output register; the next item is taken
// while it waits, and the update stalls only if the previous result is still
// there when the scan ends.
module set_membership_table_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  smt_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output smt_pkg::t_out  o_out_data
);

    smt_pkg::t_cmd  w_cmd;
    smt_pkg::t_stat w_stat;

    smt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    smt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
